/* rtl/core/cfdz_pkg.sv */
// cfdz_pkg: shared widths, register codes, payload and job types and state enum
// for the constant fraction zero-crossing timing block. No dependencies.
`default_nettype none

package cfdz_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 14;
    localparam int MAX_DELAY   = 16;
    localparam int TIME_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DLY_BITS    = 4;
    localparam int ARM_BITS    = 13;
    localparam int OFS_BITS    = 16;

    // derived widths
    localparam int OUT_BITS   = TIME_BITS + 1;
    localparam int CFD_BITS   = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int DIV_BITS   = CFD_BITS + 1;
    localparam int THR_BITS   = ARM_BITS + FRAC_BITS + 1;
    localparam int CMP_BITS   = ((CFD_BITS > THR_BITS) ? CFD_BITS : THR_BITS) + 1;
    localparam int DIDX_BITS  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CNT_BITS   = $clog2(TIME_BITS + 1);

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRACTION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARM      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET   = 2'd3;

    localparam logic [FRAC_BITS-1:0]       FRACTION_RST = 16'd49152;
    localparam logic [DLY_BITS-1:0]        DELAY_RST    = 4'd3;
    localparam logic [ARM_BITS-1:0]        ARM_RST      = 13'd100;
    localparam logic signed [OFS_BITS-1:0] OFFSET_RST   = -16'sd3;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]          sample_time;
        logic                          last_sample;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [OUT_BITS-1:0] crossing_time;
        logic                       found;
    } t_out;

    // work handed from front to back
    typedef struct packed {
        logic                 hit;
        logic                 last;
        logic [DIV_BITS-1:0]  num;
        logic [DIV_BITS-1:0]  den;
        logic [TIME_BITS-1:0] mag;
        logic                 neg;
        logic [TIME_BITS-1:0] t1;
    } t_job;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_RND,
        BK_ADD,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

/* rtl/core/cfdz_queue.sv */
// cfdz_queue: short job queue between the sample front end and the interpolating back end
// depends on cfdz_pkg
`default_nettype none

module cfdz_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire cfdz_pkg::t_job     i_job,
    input  wire logic               i_pop,
    output cfdz_pkg::t_job          o_job,
    output cfdz_pkg::t_q_status     o_status
);

    cfdz_pkg::t_job                   r_mem [cfdz_pkg::QUEUE_DEPTH];
    logic [cfdz_pkg::QPTR_BITS-1:0]   r_wr_ptr;
    logic [cfdz_pkg::QPTR_BITS-1:0]   r_rd_ptr;
    logic [cfdz_pkg::QPTR_BITS:0]     r_count;

    logic do_push;
    logic do_pop;

    // status and head
    assign o_status.full  = (r_count == (cfdz_pkg::QPTR_BITS + 1)'(cfdz_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cfdz_front.sv */
// cfdz_front: takes samples, forms the cfd value, runs the arm/crossing detector
// and queues crossing and end-of-waveform jobs; depends on cfdz_pkg
`default_nettype none

module cfdz_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire cfdz_pkg::t_in                    i_in_data,
    input  wire logic [cfdz_pkg::FRAC_BITS-1:0]   i_fraction,
    input  wire logic [cfdz_pkg::DLY_BITS-1:0]    i_delay,
    input  wire logic [cfdz_pkg::ARM_BITS-1:0]    i_arm_level,
    output logic                                  o_push,
    output cfdz_pkg::t_job                        o_job,
    input  wire cfdz_pkg::t_q_status              i_q_status
);

    // delay line
    logic signed [cfdz_pkg::SAMPLE_BITS-1:0] r_line [cfdz_pkg::MAX_DELAY];

    // product stage
    logic                                    r_a_valid;
    logic signed [cfdz_pkg::CFD_BITS-1:0]    r_a_prod;
    logic signed [cfdz_pkg::SAMPLE_BITS-1:0] r_a_dly;
    logic [cfdz_pkg::TIME_BITS-1:0]          r_a_time;
    logic                                    r_a_last;

    // detector state
    logic signed [cfdz_pkg::CFD_BITS-1:0]    r_prev_cfd;
    logic [cfdz_pkg::TIME_BITS-1:0]          r_prev_time;
    logic                                    r_armed;

    logic                                    accept;
    logic                                    fire;
    logic [cfdz_pkg::DIDX_BITS-1:0]          tap_idx;
    logic signed [cfdz_pkg::SAMPLE_BITS-1:0] delayed;
    logic signed [cfdz_pkg::CFD_BITS-1:0]    prod;
    logic signed [cfdz_pkg::CFD_BITS-1:0]    dly_shift;
    logic signed [cfdz_pkg::CFD_BITS-1:0]    cfd;
    logic signed [cfdz_pkg::CMP_BITS-1:0]    thr;
    logic                                    armed_now;
    logic                                    hit;
    logic signed [cfdz_pkg::DIV_BITS-1:0]    diff;
    logic signed [cfdz_pkg::TIME_BITS:0]     dt;
    logic [cfdz_pkg::TIME_BITS:0]            dt_abs;

    assign accept = i_in_valid && !o_in_stall;

    // pick the delayed sample; zero delay uses the current one
    always_comb begin
        if (int'(i_delay) > cfdz_pkg::MAX_DELAY) begin
            tap_idx = cfdz_pkg::DIDX_BITS'(cfdz_pkg::MAX_DELAY - 1);
        end else begin
            tap_idx = cfdz_pkg::DIDX_BITS'(int'(i_delay) - 1);
        end
        if (i_delay == '0) begin
            delayed = i_in_data.sample;
        end else begin
            delayed = r_line[tap_idx];
        end
        prod = $signed({1'b0, i_fraction}) * i_in_data.sample;
    end

    // delay line shift, cleared after the last sample of a waveform
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cfdz_pkg::MAX_DELAY; i++) begin
                r_line[i] <= '0;
            end
        end else if (accept) begin
            if (i_in_data.last_sample) begin
                for (int i = 0; i < cfdz_pkg::MAX_DELAY; i++) begin
                    r_line[i] <= '0;
                end
            end else begin
                r_line[0] <= i_in_data.sample;
                for (int i = 1; i < cfdz_pkg::MAX_DELAY; i++) begin
                    r_line[i] <= r_line[i-1];
                end
            end
        end
    end

    // product stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_prod <= prod;
            r_a_dly  <= delayed;
            r_a_time <= i_in_data.sample_time;
            r_a_last <= i_in_data.last_sample;
        end
    end

    // cfd value, arming and crossing detection
    always_comb begin
        dly_shift = cfdz_pkg::CFD_BITS'(r_a_dly) <<< cfdz_pkg::FRAC_BITS;
        cfd       = r_a_prod - dly_shift;
        thr       = -($signed(cfdz_pkg::CMP_BITS'(i_arm_level)) <<< cfdz_pkg::FRAC_BITS);
        armed_now = r_armed || (cfdz_pkg::CMP_BITS'(cfd) < thr);
        hit       = armed_now && (cfd > 0);
        diff      = cfdz_pkg::DIV_BITS'(cfd) - cfdz_pkg::DIV_BITS'(r_prev_cfd);
        dt        = $signed({1'b0, r_a_time}) - $signed({1'b0, r_prev_time});
        dt_abs    = dt[cfdz_pkg::TIME_BITS] ? (-dt) : dt;
    end

    assign fire       = r_a_valid && (!(hit || r_a_last) || !i_q_status.full);
    assign o_in_stall = r_a_valid && !fire;
    assign o_push     = r_a_valid && (hit || r_a_last) && !i_q_status.full;

    // job for the back end
    always_comb begin
        o_job.hit   = hit;
        o_job.last  = r_a_last;
        o_job.num   = (r_prev_cfd < 0) ? cfdz_pkg::DIV_BITS'(-r_prev_cfd) : '0;
        o_job.den   = diff;
        o_job.mag   = dt_abs[cfdz_pkg::TIME_BITS-1:0];
        o_job.neg   = dt[cfdz_pkg::TIME_BITS];
        o_job.t1    = r_prev_time;
    end

    // detector state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cfd  <= '0;
            r_prev_time <= '0;
            r_armed     <= 1'b0;
        end else if (fire) begin
            if (r_a_last) begin
                r_prev_cfd  <= '0;
                r_prev_time <= '0;
                r_armed     <= 1'b0;
            end else begin
                r_prev_cfd  <= cfd;
                r_prev_time <= r_a_time;
                r_armed     <= armed_now && !hit;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cfdz_back.sv */
// cfdz_back: bit-serial interpolation of queued crossings, held crossing time
// and result register; depends on cfdz_pkg
`default_nettype none

module cfdz_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire cfdz_pkg::t_job                        i_job,
    input  wire cfdz_pkg::t_q_status                   i_q_status,
    output logic                                       o_pop,
    input  wire logic signed [cfdz_pkg::OFS_BITS-1:0]  i_time_offset,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output cfdz_pkg::t_out                             o_out_data
);

    localparam int DW = cfdz_pkg::DIV_BITS;
    localparam int TW = cfdz_pkg::TIME_BITS;
    localparam int OW = cfdz_pkg::OUT_BITS;

    cfdz_pkg::t_back_state             r_state;
    cfdz_pkg::t_back_state             n_state;
    cfdz_pkg::t_job                    r_job;
    cfdz_pkg::t_job                    n_job;
    logic [DW-1:0]                     r_rem;
    logic [DW-1:0]                     n_rem;
    logic [TW-1:0]                     r_quo;
    logic [TW-1:0]                     n_quo;
    logic [TW-1:0]                     r_mag;
    logic [TW-1:0]                     n_mag;
    logic [cfdz_pkg::CNT_BITS-1:0]     r_cnt;
    logic [cfdz_pkg::CNT_BITS-1:0]     n_cnt;
    logic [TW:0]                       r_step;
    logic [TW:0]                       n_step;
    logic signed [OW-1:0]              r_held;
    logic signed [OW-1:0]              n_held;
    logic                              r_seen;
    logic                              n_seen;
    logic                              r_out_valid;
    logic                              n_out_valid;
    cfdz_pkg::t_out                    r_out_data;
    cfdz_pkg::t_out                    n_out_data;

    logic                              out_free;
    logic [DW+1:0]                     part;
    logic [DW+1:0]                     den1;
    logic [DW+1:0]                     den2;
    logic [DW+1:0]                     part_sub;
    logic [1:0]                        qdig;
    logic signed [OW:0]                held_sum;
    logic signed [OW:0]                out_sum;
    logic signed [OW-1:0]              out_sat;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cfdz_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_job.hit) begin
                        n_state = cfdz_pkg::BK_DIV;
                    end else if (i_job.last) begin
                        n_state = cfdz_pkg::BK_EMIT;
                    end
                end
            end
            cfdz_pkg::BK_DIV: begin
                if (r_cnt == cfdz_pkg::CNT_BITS'(1)) begin
                    n_state = cfdz_pkg::BK_RND;
                end
            end
            cfdz_pkg::BK_RND: begin
                n_state = cfdz_pkg::BK_ADD;
            end
            cfdz_pkg::BK_ADD: begin
                n_state = r_job.last ? cfdz_pkg::BK_EMIT : cfdz_pkg::BK_IDLE;
            end
            cfdz_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_state = cfdz_pkg::BK_IDLE;
                end
            end
            default: n_state = cfdz_pkg::BK_IDLE;
        endcase
    end

    // one quotient step: shift in the next bit of |dt| times the numerator
    always_comb begin
        den1     = (DW + 2)'(r_job.den);
        den2     = den1 << 1;
        part     = ((DW + 2)'(r_rem) << 1) +
                   (r_mag[TW-1] ? (DW + 2)'(r_job.num) : '0);
        if (part >= den2) begin
            part_sub = part - den2;
            qdig     = 2'd2;
        end else if (part >= den1) begin
            part_sub = part - den1;
            qdig     = 2'd1;
        end else begin
            part_sub = part;
            qdig     = 2'd0;
        end
    end

    // crossing time and offset result with saturation
    always_comb begin
        if (r_job.neg) begin
            held_sum = $signed((OW + 1)'(r_job.t1)) - $signed((OW + 1)'(r_step));
        end else begin
            held_sum = $signed((OW + 1)'(r_job.t1)) + $signed((OW + 1)'(r_step));
        end
        out_sum = (OW + 1)'(r_held) + (OW + 1)'(i_time_offset);
        if (out_sum[OW] != out_sum[OW-1]) begin
            out_sat = out_sum[OW] ? {1'b1, {(OW - 1){1'b0}}} : {1'b0, {(OW - 1){1'b1}}};
        end else begin
            out_sat = out_sum[OW-1:0];
        end
    end

    // datapath and outputs
    always_comb begin
        o_pop       = 1'b0;
        n_job       = r_job;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_held      = r_held;
        n_seen      = r_seen;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        case (r_state)
            cfdz_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_rem = '0;
                    n_quo = '0;
                    n_mag = i_job.mag;
                    n_cnt = cfdz_pkg::CNT_BITS'(TW);
                end
            end
            cfdz_pkg::BK_DIV: begin
                n_rem = part_sub[DW-1:0];
                n_quo = {r_quo[TW-2:0], 1'b0} + TW'(qdig);
                n_mag = {r_mag[TW-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            cfdz_pkg::BK_RND: begin
                n_step = (TW + 1)'(r_quo) + (TW + 1)'(r_rem >= (r_job.den - r_rem));
            end
            cfdz_pkg::BK_ADD: begin
                n_held = held_sum[OW-1:0];
                n_seen = 1'b1;
            end
            cfdz_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.crossing_time = r_seen ? out_sat : '0;
                    n_out_data.found         = r_seen;
                    n_held                   = '0;
                    n_seen                   = 1'b0;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfdz_pkg::BK_IDLE;
            r_held      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_mag      <= n_mag;
        r_cnt      <= n_cnt;
        r_step     <= n_step;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

/* rtl/core/cfd_zero_crossing_timing.sv */
// Constant fraction zero-crossing timing top level: config registers, front, queue, back.
// Throughput: one sample per cycle while the job queue has room; each crossing holds the back end
// for a bit-serial interpolation divide, and a 4-deep job queue absorbs them before the input stalls.
// Result path: product stage register, job queue, back end (divide, round, add for a crossing; emit), result register.
// Reset: synchronous active-low i_rst_n clears control, waveform state and restores register defaults.
// Depends on cfdz_pkg, cfdz_front, cfdz_queue, cfdz_back.
`default_nettype none

module cfd_zero_crossing_timing (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire cfdz_pkg::t_in                         i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output cfdz_pkg::t_out                             o_out_data,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [cfdz_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [cfdz_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [cfdz_pkg::FRAC_BITS-1:0]        r_fraction;
    logic [cfdz_pkg::DLY_BITS-1:0]         r_delay;
    logic [cfdz_pkg::ARM_BITS-1:0]         r_arm_level;
    logic signed [cfdz_pkg::OFS_BITS-1:0]  r_time_offset;

    logic                                  push;
    logic                                  pop;
    cfdz_pkg::t_job                        push_job;
    cfdz_pkg::t_job                        head_job;
    cfdz_pkg::t_q_status                   q_status;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fraction    <= cfdz_pkg::FRACTION_RST;
            r_delay       <= cfdz_pkg::DELAY_RST;
            r_arm_level   <= cfdz_pkg::ARM_RST;
            r_time_offset <= cfdz_pkg::OFFSET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cfdz_pkg::CFG_FRACTION: r_fraction  <= i_cfg_data[cfdz_pkg::FRAC_BITS-1:0];
                cfdz_pkg::CFG_DELAY:    r_delay     <= i_cfg_data[cfdz_pkg::DLY_BITS-1:0];
                cfdz_pkg::CFG_ARM:      r_arm_level <= i_cfg_data[cfdz_pkg::ARM_BITS-1:0];
                cfdz_pkg::CFG_OFFSET: begin
                    r_time_offset <= $signed(i_cfg_data[cfdz_pkg::OFS_BITS-1:0]);
                end
                default:                r_delay     <= r_delay;
            endcase
        end
    end

    // sample front end
    cfdz_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_fraction  (r_fraction),
        .i_delay     (r_delay),
        .i_arm_level (r_arm_level),
        .o_push      (push),
        .o_job       (push_job),
        .i_q_status  (q_status)
    );

    // job queue
    cfdz_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // interpolation and result back end
    cfdz_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .i_time_offset (r_time_offset),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire

/* tb/sv/cfd_zero_crossing_timing_tb.sv */
// cfd_zero_crossing_timing_tb: self-checking bench for the constant fraction zero-crossing block,
// with a directed table, random pulse and noise waveforms, and a sample-level predictor.
// Depends on cfdz_pkg and cfd_zero_crossing_timing.

module cfd_zero_crossing_timing_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // block ports
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_stall;
    cfdz_pkg::t_in                      i_in_data   = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    cfdz_pkg::t_out                     o_out_data;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [cfdz_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [cfdz_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    cfd_zero_crossing_timing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the configuration registers
    logic [cfdz_pkg::FRAC_BITS-1:0]       cfg_frac;
    logic [cfdz_pkg::DLY_BITS-1:0]        cfg_dly;
    logic [cfdz_pkg::ARM_BITS-1:0]        cfg_arm;
    logic signed [cfdz_pkg::OFS_BITS-1:0] cfg_ofs;

    // predicted waveform state
    logic signed [cfdz_pkg::SAMPLE_BITS-1:0] dly_taps [cfdz_pkg::MAX_DELAY];
    longint                                  last_cfd;
    logic [cfdz_pkg::TIME_BITS-1:0]          last_stamp;
    bit                                      is_armed;
    longint                                  held_time;
    bit                                      hit_seen;

    // expected timing reports, oldest first
    cfdz_pkg::t_out pending_reports [$];
    cfdz_pkg::t_out oldest;

    int mismatch_count = 0;
    int reports_seen   = 0;
    int items_sent     = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    logic [cfdz_pkg::TIME_BITS-1:0] stamp;

    // directed stimulus rows: either a register set or one sample
    typedef struct {
        bit                                   is_cfg;
        logic [cfdz_pkg::FRAC_BITS-1:0]       frac;
        logic [cfdz_pkg::DLY_BITS-1:0]        dly;
        logic [cfdz_pkg::ARM_BITS-1:0]        arm;
        logic signed [cfdz_pkg::OFS_BITS-1:0] ofs;
        cfdz_pkg::t_in                        item;
        bit                                   typed;
        cfdz_pkg::t_out                       want;
    } t_dir_row;

    t_dir_row dir_rows [$];

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at result %0d: %s got %0d want %0d",
                     reports_seen, what, got, want);
        end
    endtask

    function automatic void clear_waveform();
        foreach (dly_taps[n]) dly_taps[n] = '0;
        last_cfd   = 0;
        last_stamp = '0;
        is_armed   = 1'b0;
        held_time  = 0;
        hit_seen   = 1'b0;
    endfunction

    // one sample through the discriminator; a report comes out on the last sample
    function automatic void discriminate(input cfdz_pkg::t_in x, output bit has_res,
                                         output cfdz_pkg::t_out res);
        longint      s, delayed, fr, thr, cfd, a, c, now_l, prev_l, dt, mag, t;
        logic [95:0] prod, cc, q, r;
        s = x.sample;
        delayed = (cfg_dly == 0) ? s : longint'(dly_taps[cfg_dly - 1]);
        for (int n = cfdz_pkg::MAX_DELAY - 1; n > 0; n--) dly_taps[n] = dly_taps[n - 1];
        dly_taps[0] = x.sample;

        fr  = cfg_frac;
        cfd = fr * s - 64'sd65536 * delayed;
        thr = cfg_arm;
        thr = thr * 64'sd65536;

        if (!is_armed && cfd < -thr) is_armed = 1'b1;
        // armed and back above zero: interpolate between previous and current stamp
        if (is_armed && cfd > 0) begin
            a      = (last_cfd < 0) ? -last_cfd : 0;
            c      = cfd - last_cfd;
            now_l  = x.sample_time;
            prev_l = last_stamp;
            dt     = now_l - prev_l;
            mag    = (dt < 0) ? -dt : dt;
            prod   = 96'(a) * 96'(mag);
            cc     = 96'(c);
            q      = prod / cc;
            r      = prod % cc;
            if (r >= cc - r) q++;
            held_time = (dt < 0) ? prev_l - longint'(q[63:0]) : prev_l + longint'(q[63:0]);
            hit_seen  = 1'b1;
            is_armed  = 1'b0;
        end
        last_cfd   = cfd;
        last_stamp = x.sample_time;

        has_res = x.last_sample;
        res     = '0;
        if (x.last_sample) begin
            t = 0;
            if (hit_seen) begin
                t = held_time + cfg_ofs;
                if (t > 64'sh0_FFFF_FFFF) t = 64'sh0_FFFF_FFFF;
                if (t < -64'sh1_0000_0000) t = -64'sh1_0000_0000;
            end
            res.crossing_time = t[cfdz_pkg::OUT_BITS-1:0];
            res.found         = hit_seen;
            clear_waveform();
        end
    endfunction

    // sample transfer with optional sender gaps; prediction on acceptance
    task automatic send_item(cfdz_pkg::t_in item, bit typed = 1'b0,
                             cfdz_pkg::t_out want = '0);
        bit             has_res;
        cfdz_pkg::t_out res;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        discriminate(item, has_res, res);
        if (has_res) pending_reports.insert(pending_reports.size(), typed ? want : res);
    endtask

    // stop offering samples, let all reports come back and the back end settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (cfdz_pkg::TIME_BITS + 10) @(posedge i_clk);
    endtask

    // write all four registers back to back
    task automatic write_config(logic [cfdz_pkg::FRAC_BITS-1:0] frac,
                                logic [cfdz_pkg::DLY_BITS-1:0] dly,
                                logic [cfdz_pkg::ARM_BITS-1:0] arm,
                                logic signed [cfdz_pkg::OFS_BITS-1:0] ofs);
        logic [cfdz_pkg::CFG_IDX_BITS-1:0]  idx [4];
        logic [cfdz_pkg::CFG_DATA_BITS-1:0] val [4];
        idx = '{cfdz_pkg::CFG_FRACTION, cfdz_pkg::CFG_DELAY, cfdz_pkg::CFG_ARM,
                cfdz_pkg::CFG_OFFSET};
        val = '{frac, 16'(dly), 16'(arm), ofs};
        for (int n = 0; n < 4; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[n];
            i_cfg_data  <= val[n];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cfg_frac = frac;
        cfg_dly  = dly;
        cfg_arm  = arm;
        cfg_ofs  = ofs;
    endtask

    // negative (sometimes positive) pulse on a noisy baseline, mostly steady stamps
    task automatic send_pulse(int min_len);
        int                             len, start, rise, hold, amp, noise, k, lvl, v;
        bit                             flip;
        logic [cfdz_pkg::TIME_BITS-1:0] inc;
        cfdz_pkg::t_in                  item;
        len   = $urandom_range(min_len, 40);
        start = $urandom_range(0, len / 3);
        rise  = $urandom_range(1, 6);
        hold  = $urandom_range(0, 20);
        amp   = $urandom_range(50, 8192);
        noise = $urandom_range(0, 40);
        flip  = ($urandom_range(5) == 0);
        stamp = $urandom;
        inc   = $urandom_range(1, 2000);
        for (int i = 0; i < len; i++) begin
            k = i - start;
            if (k < 0) lvl = 0;
            else if (k < rise) lvl = amp * (k + 1) / rise;
            else if (k < rise + hold) lvl = amp;
            else lvl = amp - amp * (k - rise - hold + 1) / rise;
            if (lvl < 0) lvl = 0;
            v = int'($urandom_range(0, 2 * noise)) - noise;
            v = v + (flip ? lvl : -lvl);
            if (v > 8191) v = 8191;
            if (v < -8192) v = -8192;
            if ($urandom_range(19) == 0) stamp = $urandom;
            else stamp = stamp + inc;
            item.sample      = v[cfdz_pkg::SAMPLE_BITS-1:0];
            item.sample_time = stamp;
            item.last_sample = (i == len - 1);
            send_item(item);
        end
    endtask

    // fully random samples and stamps
    task automatic send_noise();
        int            len;
        cfdz_pkg::t_in item;
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
            item.sample      = 14'($urandom);
            item.sample_time = $urandom;
            item.last_sample = (i == len - 1);
            send_item(item);
        end
    endtask

    function automatic void add_item(logic signed [cfdz_pkg::SAMPLE_BITS-1:0] s,
                                     logic [cfdz_pkg::TIME_BITS-1:0] ts,
                                     bit last, bit typed = 1'b0,
                                     cfdz_pkg::t_out want = '0);
        t_dir_row row;
        row                  = '{default: '0};
        row.item.sample      = s;
        row.item.sample_time = ts;
        row.item.last_sample = last;
        row.typed            = typed;
        row.want             = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void add_cfg(logic [cfdz_pkg::FRAC_BITS-1:0] frac,
                                    logic [cfdz_pkg::DLY_BITS-1:0] dly,
                                    logic [cfdz_pkg::ARM_BITS-1:0] arm,
                                    logic signed [cfdz_pkg::OFS_BITS-1:0] ofs);
        t_dir_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.frac   = frac;
        row.dly    = dly;
        row.arm    = arm;
        row.ofs    = ofs;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // receiver stall: long hold-off on request, otherwise random
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // result transfers against the oldest expected report
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                report_mismatch("result with nothing pending", o_out_data.crossing_time, 0);
            end else begin
                oldest = pending_reports.pop_front();
                if (o_out_data.crossing_time !== oldest.crossing_time) begin
                    report_mismatch("crossing_time", o_out_data.crossing_time,
                                    oldest.crossing_time);
                end
                if (o_out_data.found !== oldest.found) begin
                    report_mismatch("found", o_out_data.found, oldest.found);
                end
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial begin
        int target;
        cfg_frac = cfdz_pkg::FRACTION_RST;
        cfg_dly  = cfdz_pkg::DELAY_RST;
        cfg_arm  = cfdz_pkg::ARM_RST;
        cfg_ofs  = cfdz_pkg::OFFSET_RST;
        clear_waveform();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone last sample after reset reports nothing found
        add_item(14'sd0, 32'd0, 1'b1, 1'b1, '{33'sd0, 1'b0});
        // full-scale negative step under the reset settings, crossing on the last sample
        add_item(14'sd8191, 32'd5, 1'b0);
        add_item(-14'sd8192, 32'd10, 1'b0);
        add_item(-14'sd8192, 32'd20, 1'b0);
        add_item(-14'sd8192, 32'd30, 1'b0);
        add_item(-14'sd8192, 32'd40, 1'b1);
        // same shape with stamps running backwards
        add_item(14'sd8191, 32'd1000, 1'b0);
        add_item(-14'sd8192, 32'd900, 1'b0);
        add_item(-14'sd8192, 32'd800, 1'b0);
        add_item(-14'sd8192, 32'd700, 1'b0);
        add_item(-14'sd8192, 32'd600, 1'b1);
        // crossing near the top of the stamp range plus maximum offset saturates
        add_cfg(cfdz_pkg::FRACTION_RST, cfdz_pkg::DELAY_RST, cfdz_pkg::ARM_RST, 16'sh7FFF);
        add_item(14'sd8191, 32'hFFFF_FF00, 1'b0);
        add_item(-14'sd8192, 32'hFFFF_FF10, 1'b0);
        add_item(-14'sd8192, 32'hFFFF_FF20, 1'b0);
        add_item(-14'sd8192, 32'hFFFF_FF30, 1'b0);
        add_item(-14'sd8192, 32'hFFFF_FF40, 1'b1, 1'b1, '{33'sh0_FFFF_FFFF, 1'b1});
        // zero delay, zero fraction: cfd exactly at the arm level does not arm
        add_cfg(16'h0000, 4'd0, 13'h1FFF, 16'sh8000);
        add_item(14'sd8191, 32'd7, 1'b0);
        add_item(-14'sd8192, 32'd8, 1'b1, 1'b1, '{33'sd0, 1'b0});
        // zero delay, full fraction, zero arm level, stamp wraps to zero
        add_cfg(16'hFFFF, 4'd0, 13'd0, 16'sh8000);
        add_item(14'sd1, 32'hFFFF_FFFF, 1'b0);
        add_item(-14'sd1, 32'd0, 1'b1);
        add_cfg(cfdz_pkg::FRACTION_RST, cfdz_pkg::DELAY_RST, cfdz_pkg::ARM_RST,
                cfdz_pkg::OFFSET_RST);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                wait_idle();
                write_config(dir_rows[n].frac, dir_rows[n].dly, dir_rows[n].arm,
                             dir_rows[n].ofs);
            end else begin
                send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);
            end
        end

        // back-pressure: receiver holds off while pulses keep coming, then full drain
        wait_idle();
        hold_req = 400;
        for (int n = 0; n < 12; n++) send_pulse(8);
        wait_idle();

        // random phases under three idle patterns, new settings per phase
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 50 : 0;
            rx_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 8 : 0;
            for (int ph = 0; ph < 5; ph++) begin
                wait_idle();
                if (mode == 0 && ph == 0) begin
                    write_config(16'hFFFF, 4'd15, 13'd0, 16'sh7FFF);
                end else if (mode == 1 && ph == 0) begin
                    write_config(16'h0000, 4'd1, 13'h1FFF, 16'sh8000);
                end else begin
                    write_config(16'($urandom), 4'($urandom),
                                 ($urandom_range(3) == 0) ? 13'($urandom)
                                                          : 13'($urandom_range(400)),
                                 16'($urandom));
                end
                target = items_sent + 70;
                while (items_sent < target) begin
                    if ($urandom_range(4) == 0) send_noise();
                    else send_pulse(1);
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* cfd_zero_crossing_timing.f */
rtl/core/cfdz_pkg.sv
rtl/core/cfdz_queue.sv
rtl/core/cfdz_front.sv
rtl/core/cfdz_back.sv
rtl/core/cfd_zero_crossing_timing.sv
tb/sv/cfd_zero_crossing_timing_tb.sv
